// ===== design/lga_pkg.sv =====
// Shared types, grid geometry and codes for the life automaton block.
`timescale 1ns / 1ps

package lga_pkg;

  // Grid geometry
  localparam int GRID_COLS  = 64;
  localparam int GRID_ROWS  = 64;
  localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;

  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int POP_W  = $clog2(GRID_CELLS + 1);
  // Sweep slots: one per cell plus one row and one cell of look-ahead
  localparam int SEQ_W  = $clog2(GRID_CELLS + GRID_COLS + 1);
  // Three-row neighborhood window
  localparam int WIN_W  = 2 * GRID_COLS + 3;

  // Field widths
  localparam int KIND_W    = 3;
  localparam int INDEX_W   = 12;
  localparam int POP_OUT_W = 13;
  localparam int GEN_W     = 32;
  localparam int RULE_W    = 4;
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_SET   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KILL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_COUNT = 2'd2;

  // Register reset values (B3/S23)
  localparam logic [RULE_W-1:0] RST_SURVIVE_MIN = 4'd2;
  localparam logic [RULE_W-1:0] RST_SURVIVE_MAX = 4'd3;
  localparam logic [RULE_W-1:0] RST_BIRTH_COUNT = 4'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic                 cell_alive;
    logic                 changed;
    logic [POP_OUT_W-1:0] population;
    logic [GEN_W-1:0]     generation;
  } out_t;

  typedef struct packed {
    logic [RULE_W-1:0] survive_min;
    logic [RULE_W-1:0] survive_max;
    logic [RULE_W-1:0] birth_count;
  } cfg_t;

endpackage

// ===== design/life_automaton_grid_step_top.sv =====
// Top level: register port, request/result handshakes and the cell engine.
`timescale 1ns / 1ps

// Bounded 64 by 64 life grid (B3/S23 by default, limits programmable) held
// in a one-bit-per-cell memory with one read and one write port. Set, kill
// and query requests pass through a memory read state, then an update
// state, before their result. A generation step sweeps the memory in raster
// order through a three-row shift window and one shared neighbor-count/rule
// unit, one cell per cycle, writing each new state back once its old value
// has been read into the window. Clear writes every cell. After reset a
// clearing pass over every cell runs with in_ready low; register writes are
// taken at any time but must only be issued while the block is idle. One
// request is worked on at a time; the next is accepted while a finished
// result waits in the output register.

module life_automaton_grid_step_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lga_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lga_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [lga_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lga_pkg::RULE_W-1:0]      cfg_wdata
);

  lga_pkg::cfg_t cfg_r;
  logic          eng_idle;
  logic          res_valid;
  logic          res_ready;
  lga_pkg::out_t res;
  logic          out_valid_r;
  lga_pkg::out_t out_data_r;

  // Rule registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.survive_min <= lga_pkg::RST_SURVIVE_MIN;
      cfg_r.survive_max <= lga_pkg::RST_SURVIVE_MAX;
      cfg_r.birth_count <= lga_pkg::RST_BIRTH_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx)
        lga_pkg::CFG_SURVIVE_MIN: cfg_r.survive_min <= cfg_wdata;
        lga_pkg::CFG_SURVIVE_MAX: cfg_r.survive_max <= cfg_wdata;
        lga_pkg::CFG_BIRTH_COUNT: cfg_r.birth_count <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_ready  = eng_idle;
  assign res_ready = ~out_valid_r | out_ready;

  lga_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid & eng_idle),
    .req       (in_data),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lga_rule.sv =====
// Neighbor count and survive/birth decision for one cell.
`timescale 1ns / 1ps

module lga_rule (
  input  logic [7:0]    nbr,
  input  logic          alive,
  input  lga_pkg::cfg_t cfg,
  output logic          nxt
);

  logic [lga_pkg::RULE_W-1:0] cnt;

  // Population count of the eight (masked) neighbors
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + lga_pkg::RULE_W'(nbr[i]);
    end
  end

  // Live cell survives inside the limits, dead cell born on exact match
  always_comb begin
    if (alive) begin
      nxt = (cnt >= cfg.survive_min) && (cnt <= cfg.survive_max);
    end else begin
      nxt = (cnt == cfg.birth_count);
    end
  end

endmodule

// ===== design/lga_engine.sv =====
// Cell memory, raster sweep sequencer and single-cell read-modify-write.
`timescale 1ns / 1ps

module lga_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  lga_pkg::in_t  req,
  input  lga_pkg::cfg_t cfg,
  input  logic          res_ready,
  output logic          idle,
  output logic          res_valid,
  output lga_pkg::out_t res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLR   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  localparam int CELLS = lga_pkg::GRID_CELLS;
  localparam int COLS  = lga_pkg::GRID_COLS;
  localparam int AW    = lga_pkg::ADDR_W;
  localparam int SW    = lga_pkg::SEQ_W;
  localparam int WW    = lga_pkg::WIN_W;
  localparam int PW    = lga_pkg::POP_W;

  logic [2:0]                 state_r;
  logic [SW-1:0]              seq_r;
  logic                       iss_r;
  logic                       v1_r, e1_r, in1_r;
  logic                       v2_r, e2_r;
  logic [WW-1:0]              win_r;
  logic [AW-1:0]              cen_idx_r;
  logic [lga_pkg::COL_W-1:0]  cen_col_r;
  logic [lga_pkg::ROW_W-1:0]  cen_row_r;
  logic [PW-1:0]              pop_acc_r;
  logic [PW-1:0]              live_r;
  logic [PW-1:0]              live_nxt;
  logic [lga_pkg::GEN_W-1:0]  gen_r;
  logic                       rpt_r;
  lga_pkg::in_t               req_r;
  logic                       inside_r;
  logic                       rd_data_r;

  logic mem [CELLS];

  logic          mem_re, mem_we, mem_wd;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [AW-1:0] seq_addr, req_addr;
  logic          seq_in, last_iss, rd_bit, eval, cen_last;
  logic          up_ok, dn_ok, lf_ok, rt_ok;
  logic [7:0]    nbr;
  logic          rule_nxt;
  logic          old_bit, is_set, is_kill, chg, new_bit;

  assign seq_addr = AW'(seq_r);
  assign req_addr = AW'(req_r.cell_index);
  assign seq_in   = seq_r < SW'(CELLS);
  assign last_iss = seq_r == SW'(CELLS + COLS);
  assign rd_bit   = in1_r & rd_data_r;
  assign eval     = (state_r == ST_SWEEP) && v2_r && e2_r;
  assign cen_last = cen_idx_r == AW'(CELLS - 1);

  // Window taps: newest bit is one row and one cell past the center
  assign up_ok = cen_row_r != '0;
  assign dn_ok = cen_row_r != lga_pkg::ROW_W'(lga_pkg::GRID_ROWS - 1);
  assign lf_ok = cen_col_r != '0;
  assign rt_ok = cen_col_r != lga_pkg::COL_W'(COLS - 1);

  assign nbr[0] = win_r[2*COLS+2] & up_ok & lf_ok;
  assign nbr[1] = win_r[2*COLS+1] & up_ok;
  assign nbr[2] = win_r[2*COLS]   & up_ok & rt_ok;
  assign nbr[3] = win_r[COLS+2]   & lf_ok;
  assign nbr[4] = win_r[COLS]     & rt_ok;
  assign nbr[5] = win_r[2]        & dn_ok & lf_ok;
  assign nbr[6] = win_r[1]        & dn_ok;
  assign nbr[7] = win_r[0]        & dn_ok & rt_ok;

  lga_rule u_rule (
    .nbr   (nbr),
    .alive (win_r[COLS+1]),
    .cfg   (cfg),
    .nxt   (rule_nxt)
  );

  // Single-cell update
  assign old_bit = inside_r & rd_data_r;
  assign is_set  = req_r.kind == lga_pkg::KIND_SET;
  assign is_kill = req_r.kind == lga_pkg::KIND_KILL;
  assign chg     = inside_r & ((is_set & ~old_bit) | (is_kill & old_bit));
  assign new_bit = chg ? ~old_bit : old_bit;

  always_comb begin
    live_nxt = live_r;
    if (chg && is_set) begin
      live_nxt = live_r + PW'(1);
    end else if (chg) begin
      live_nxt = live_r - PW'(1);
    end
  end

  // Memory port selection
  always_comb begin
    mem_re = 1'b0;
    mem_ra = seq_addr;
    mem_we = 1'b0;
    mem_wa = seq_addr;
    mem_wd = 1'b0;
    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_SWEEP: begin
        mem_re = iss_r & seq_in;
        mem_we = eval;
        mem_wa = cen_idx_r;
        mem_wd = rule_nxt;
      end
      ST_RD: begin
        mem_re = inside_r;
        mem_ra = req_addr;
      end
      ST_UPD: begin
        mem_we = res_ready & chg;
        mem_wa = req_addr;
        mem_wd = new_bit;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Cell memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Window shift line (payload, no reset)
  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP && v1_r) begin
      win_r <= {win_r[WW-2:0], rd_bit};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      seq_r     <= '0;
      iss_r     <= 1'b0;
      v1_r      <= 1'b0;
      e1_r      <= 1'b0;
      in1_r     <= 1'b0;
      v2_r      <= 1'b0;
      e2_r      <= 1'b0;
      cen_idx_r <= '0;
      cen_col_r <= '0;
      cen_row_r <= '0;
      pop_acc_r <= '0;
      live_r    <= '0;
      gen_r     <= '0;
      rpt_r     <= 1'b0;
      req_r     <= '0;
      inside_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r    <= req;
            inside_r <= 32'(req.cell_index) < 32'(CELLS);
            seq_r    <= '0;
            case (req.kind)
              lga_pkg::KIND_STEP: begin
                state_r   <= ST_SWEEP;
                iss_r     <= 1'b1;
                v1_r      <= 1'b0;
                v2_r      <= 1'b0;
                cen_idx_r <= '0;
                cen_col_r <= '0;
                cen_row_r <= '0;
                pop_acc_r <= '0;
              end
              lga_pkg::KIND_CLEAR: begin
                state_r <= ST_CLR;
                rpt_r   <= 1'b1;
              end
              default: begin
                state_r <= ST_RD;
              end
            endcase
          end
        end
        ST_CLR: begin
          seq_r <= seq_r + SW'(1);
          if (seq_r == SW'(CELLS - 1)) begin
            live_r  <= '0;
            gen_r   <= '0;
            state_r <= rpt_r ? ST_RD : ST_IDLE;
          end
        end
        ST_SWEEP: begin
          // read issue
          if (iss_r) begin
            seq_r <= seq_r + SW'(1);
            if (last_iss) begin
              iss_r <= 1'b0;
            end
          end
          v1_r  <= iss_r;
          e1_r  <= seq_r >= SW'(COLS + 1);
          in1_r <= seq_in;
          v2_r  <= v1_r;
          e2_r  <= e1_r;
          // evaluate center cell
          if (eval) begin
            pop_acc_r <= pop_acc_r + PW'(rule_nxt);
            cen_idx_r <= cen_idx_r + AW'(1);
            if (cen_col_r == lga_pkg::COL_W'(COLS - 1)) begin
              cen_col_r <= '0;
              cen_row_r <= cen_row_r + lga_pkg::ROW_W'(1);
            end else begin
              cen_col_r <= cen_col_r + lga_pkg::COL_W'(1);
            end
            if (cen_last) begin
              live_r  <= pop_acc_r + PW'(rule_nxt);
              gen_r   <= gen_r + lga_pkg::GEN_W'(1);
              iss_r   <= 1'b0;
              v1_r    <= 1'b0;
              v2_r    <= 1'b0;
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (res_ready) begin
            live_r  <= live_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle      = state_r == ST_IDLE;
  assign res_valid = (state_r == ST_UPD) && res_ready;

  always_comb begin
    res.cell_alive = new_bit;
    res.changed    = chg;
    res.population = lga_pkg::POP_OUT_W'(live_nxt);
    res.generation = gen_r;
  end

endmodule
